/* design/lsii_pkg.sv */
// Package for the linear spline interpolation / integral core.
// Holds table size, status codes, sequencer state type and saturating add.
// No dependencies.
package lsii_pkg;

  localparam int MAX_KNOTS = 64;
  localparam int IDXW      = $clog2(MAX_KNOTS);
  localparam int CNTW      = 7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_R0, S_R1, S_R2, S_BIS, S_BISC, S_WI, S_WU, S_TMUL, S_TACC,
    S_PMUL, S_DIV1, S_IV, S_YMUL, S_YACC, S_QMUL, S_RMUL, S_DIV2, S_FIN, S_EMIT
  } state_t;

  // 64-bit signed add, clamped to the signed range
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_add = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = s;
    end
  endfunction

endpackage

/* design/linear_spline_interp_integral_core.sv */
// Top level of the linear spline interpolation / integral core.
// Knot tables, bisection and walk sequencer, shared multiplier and divider.
// Depends on lsii_pkg.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------
//  in      | input     | in_valid/in_stall | kind, knot_index, knot_x/y, query_z
//  out     | output    | out_valid/out_stall | interp_value, integral_value, status
//  cfg     | input     | cfg_wr_en         | cfg_wr_data (knot_count)
//
// A load transfer writes the tables in the accept cycle.
// A query holds in_stall while the sequencer runs the bisection, the walk with a
// trapezoid pass per whole interval through the shared 33x16 multiplier, and
// two 64-bit divides in the shared divider, and until its result is emitted. A
// query outside the table skips the bisection and the walk and goes to emit.
// Reset (rst_n low, synchronous) clears the sequencer, out_valid and
// knot_count (to 2); the tables are not cleared.
// in_stall is high while a query is in flight; a finished result waits in the
// output register until out_stall drops.
module linear_spline_interp_integral_core
  import lsii_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [5:0]          in_knot_index,
  input  logic signed [31:0]  in_knot_x,
  input  logic signed [31:0]  in_knot_y,
  input  logic signed [31:0]  in_query_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_interp_value,
  output logic signed [63:0]  out_integral_value,
  output logic [1:0]          out_status,
  input  logic                cfg_wr_en,
  input  logic [CNTW-1:0]     cfg_wr_data
);

  localparam logic signed [63:0] IV_MAX = 64'sd2147483647;
  localparam logic signed [63:0] IV_MIN = -64'sd2147483648;

  // knot tables
  logic signed [31:0] x_mem [MAX_KNOTS];
  logic signed [31:0] y_mem [MAX_KNOTS];
  logic signed [31:0] rx_r, ry_r;
  logic [IDXW-1:0]    rd_addr;

  state_t state_r, state_nxt;

  logic [CNTW-1:0]    kcnt_r;
  logic signed [31:0] z_r, z_nxt;
  logic signed [31:0] xf_r, xf_nxt;
  logic [IDXW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, k_r, k_nxt;
  logic signed [31:0] xp_r, xp_nxt, yp_r, yp_nxt;
  logic [31:0]        w_r, w_nxt, t_r, t_nxt;
  logic               tneg_r, tneg_nxt, dneg_r, dneg_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [31:0] iv_r, iv_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic [32:0]        q_r, q_nxt;
  logic [31:0]        r_r, r_nxt;
  logic [63:0]        qa_r, qa_nxt;
  // shared multiplier: opa * opb, low then high 16 bits of opb, one per phase
  logic [32:0]        opa_r, opa_nxt;
  logic [31:0]        opb_r, opb_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic               ph_r, ph_nxt;
  // shared divider: restoring, one quotient bit per cycle
  logic [63:0]        dvd_r, dvd_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [6:0]         dcnt_r, dcnt_nxt;
  logic               out_valid_r;
  logic signed [31:0] o_iv_r;
  logic signed [63:0] o_acc_r;
  logic [1:0]         o_stat_r;

  logic               in_acc;
  logic [IDXW:0]      n_c;
  logic [IDXW:0]      mid_sum;
  logic [IDXW-1:0]    mid;
  logic               emit_go;

  // multiplier / divider datapath pieces
  logic [15:0]        mhalf;
  logic [48:0]        pp;
  logic               mul_state;
  logic [32:0]        trial;
  logic               tbit;

  assign in_acc  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign emit_go = !out_valid_r || !out_stall;

  // clamp knot_count to [2, MAX_KNOTS]
  always_comb begin
    if (kcnt_r < CNTW'(2)) begin
      n_c = (IDXW+1)'(2);
    end else if (32'(kcnt_r) > MAX_KNOTS) begin
      n_c = (IDXW+1)'(MAX_KNOTS);
    end else begin
      n_c = (IDXW+1)'(kcnt_r);
    end
  end

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[IDXW:1];

  always_ff @(posedge clk) begin
    if (in_acc && !in_kind && (32'(in_knot_index) < MAX_KNOTS)) begin
      x_mem[in_knot_index[IDXW-1:0]] <= in_knot_x;
      y_mem[in_knot_index[IDXW-1:0]] <= in_knot_y;
    end
    rx_r <= x_mem[rd_addr];
    ry_r <= y_mem[rd_addr];
  end

  always_comb begin
    case (state_r)
      S_R0:    rd_addr = '0;
      S_R1:    rd_addr = IDXW'(n_c - (IDXW+1)'(1));
      S_BIS:   rd_addr = mid;
      S_WI:    rd_addr = k_r;
      default: rd_addr = '0;
    endcase
  end

  assign mul_state = (state_r == S_TMUL) || (state_r == S_PMUL) || (state_r == S_YMUL)
                  || (state_r == S_QMUL) || (state_r == S_RMUL);
  assign mhalf = ph_r ? opb_r[31:16] : opb_r[15:0];
  assign pp    = opa_r * mhalf;
  assign trial = {rem_r, dvd_r[63]};
  assign tbit  = (trial >= {1'b0, w_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc && in_kind) state_nxt = S_R0;
      S_R0:   state_nxt = S_R1;
      S_R1:   state_nxt = S_R2;
      S_R2: begin
        if (z_r < xf_r || z_r > rx_r) state_nxt = S_EMIT;
        else state_nxt = S_BIS;
      end
      S_BIS:  state_nxt = (hi_r - lo_r > IDXW'(1)) ? S_BISC : S_WI;
      S_BISC: state_nxt = S_BIS;
      S_WI:   state_nxt = S_WU;
      S_WU: begin
        if (k_r == '0) state_nxt = S_WI;
        else if (rx_r <= xp_r) state_nxt = S_EMIT;
        else if (k_r <= lo_r) state_nxt = S_TMUL;
        else state_nxt = S_PMUL;
      end
      S_TMUL: if (ph_r) state_nxt = S_TACC;
      S_TACC: state_nxt = S_WI;
      S_PMUL: if (ph_r) state_nxt = S_DIV1;
      S_DIV1: if (dcnt_r == 7'd63) state_nxt = S_IV;
      S_IV:   state_nxt = S_YMUL;
      S_YMUL: if (ph_r) state_nxt = S_YACC;
      S_YACC: state_nxt = S_QMUL;
      S_QMUL: if (ph_r) state_nxt = S_RMUL;
      S_RMUL: if (ph_r) state_nxt = S_DIV2;
      S_DIV2: if (dcnt_r == 7'd63) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_EMIT;
      S_EMIT: if (emit_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic signed [32:0] ys, dy;
    logic [32:0]        mys;
    logic [63:0]        h, a;
    logic [32:0]        qi;
    logic signed [63:0] dl, ivw;
    z_nxt = z_r;  xf_nxt = xf_r;  lo_nxt = lo_r;  hi_nxt = hi_r;  k_nxt = k_r;
    xp_nxt = xp_r;  yp_nxt = yp_r;  w_nxt = w_r;  t_nxt = t_r;
    tneg_nxt = tneg_r;  dneg_nxt = dneg_r;  acc_nxt = acc_r;  iv_nxt = iv_r;
    stat_nxt = stat_r;  q_nxt = q_r;  r_nxt = r_r;  qa_nxt = qa_r;
    opa_nxt = opa_r;  opb_nxt = opb_r;  dvd_nxt = dvd_r;  rem_nxt = rem_r;
    dcnt_nxt = dcnt_r;
    ys = 33'(yp_r) + 33'(ry_r);
    mys = ys[32] ? 33'(-ys) : 33'(ys);
    dy = 33'(ry_r) - 33'(yp_r);
    h = '0;  a = '0;  qi = '0;  dl = '0;  ivw = '0;

    ph_nxt   = mul_state ? !ph_r : 1'b0;
    prod_nxt = ph_r ? prod_r + (64'(pp) << 16) : 64'(pp);
    if (!mul_state) prod_nxt = prod_r;

    case (state_r)
      S_IDLE: begin
        z_nxt = in_query_z;
        acc_nxt = '0;
        iv_nxt = '0;
        stat_nxt = ST_OK;
      end
      S_R1: xf_nxt = rx_r;
      S_R2: begin
        stat_nxt = (z_r < xf_r || z_r > rx_r) ? ST_RANGE : ST_OK;
        lo_nxt = '0;
        hi_nxt = IDXW'(n_c - (IDXW+1)'(1));
        k_nxt = '0;
      end
      S_BISC: begin
        if (z_r > rx_r) lo_nxt = mid;
        else hi_nxt = mid;
      end
      S_WU: begin
        if (k_r == '0) begin
          xp_nxt = rx_r;
          yp_nxt = ry_r;
          k_nxt = k_r + IDXW'(1);
        end else if (rx_r <= xp_r) begin
          stat_nxt = ST_ORDER;
        end else if (k_r <= lo_r) begin
          opa_nxt = mys;
          opb_nxt = 32'(rx_r - xp_r);
          tneg_nxt = ys[32];
          xp_nxt = rx_r;
          yp_nxt = ry_r;
        end else begin
          // final interval: yp is y0, read data is x1/y1
          w_nxt = 32'(rx_r - xp_r);
          t_nxt = 32'(z_r - xp_r);
          dneg_nxt = dy[32];
          opa_nxt = dy[32] ? 33'(-dy) : 33'(dy);
          opb_nxt = 32'(z_r - xp_r);
        end
      end
      S_TACC: begin
        h = (prod_r + 64'd1) >> 1;
        acc_nxt = sat_add(acc_r, tneg_r ? -$signed(h) : $signed(h));
        k_nxt = k_r + IDXW'(1);
      end
      S_DIV1, S_DIV2: begin
        dvd_nxt = {dvd_r[62:0], tbit};
        rem_nxt = tbit ? 32'(trial - {1'b0, w_r}) : trial[31:0];
        dcnt_nxt = dcnt_r + 7'd1;
      end
      S_IV: begin
        // round half away from zero on the magnitude
        qi = (rem_r >= w_r - rem_r) ? dvd_r[32:0] + 33'd1 : dvd_r[32:0];
        dl = dneg_r ? -$signed(64'(qi)) : $signed(64'(qi));
        ivw = 64'(yp_r) + dl;
        if (ivw > IV_MAX) iv_nxt = 32'(IV_MAX);
        else if (ivw < IV_MIN) iv_nxt = 32'(IV_MIN);
        else iv_nxt = 32'(ivw);
        q_nxt = dvd_r[32:0];
        r_nxt = rem_r;
        opa_nxt = yp_r[31] ? 33'(-33'(yp_r)) : 33'(yp_r);
        opb_nxt = t_r;
      end
      S_YACC: begin
        acc_nxt = sat_add(acc_r, yp_r[31] ? -$signed(prod_r) : $signed(prod_r));
        opa_nxt = q_r;
        opb_nxt = t_r;
      end
      S_FIN: begin
        a = qa_r + dvd_r;
        h = (a + 64'd1) >> 1;
        acc_nxt = sat_add(acc_r, dneg_r ? -$signed(h) : $signed(h));
      end
      default: ;
    endcase

    // divider start after PMUL and RMUL; QMUL result handoff
    if (mul_state && ph_r) begin
      if (state_r == S_PMUL || state_r == S_RMUL) begin
        dvd_nxt = prod_nxt;
        rem_nxt = '0;
        dcnt_nxt = '0;
      end
      if (state_r == S_QMUL) begin
        qa_nxt = prod_nxt;
        opa_nxt = {1'b0, r_r};
        opb_nxt = t_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kcnt_r      <= CNTW'(2);
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      if (cfg_wr_en) kcnt_r <= cfg_wr_data;
      if (state_r == S_EMIT && emit_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    z_r <= z_nxt;  xf_r <= xf_nxt;  lo_r <= lo_nxt;  hi_r <= hi_nxt;  k_r <= k_nxt;
    xp_r <= xp_nxt;  yp_r <= yp_nxt;  w_r <= w_nxt;  t_r <= t_nxt;
    tneg_r <= tneg_nxt;  dneg_r <= dneg_nxt;  acc_r <= acc_nxt;  iv_r <= iv_nxt;
    stat_r <= stat_nxt;  q_r <= q_nxt;  r_r <= r_nxt;  qa_r <= qa_nxt;
    opa_r <= opa_nxt;  opb_r <= opb_nxt;  prod_r <= prod_nxt;
    dvd_r <= dvd_nxt;  rem_r <= rem_nxt;  dcnt_r <= dcnt_nxt;
    if (state_r == S_EMIT && emit_go) begin
      o_stat_r <= stat_r;
      o_iv_r   <= (stat_r == ST_OK) ? iv_r : '0;
      o_acc_r  <= (stat_r == ST_OK) ? acc_r : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_interp_value   = o_iv_r;
  assign out_integral_value = o_acc_r;
  assign out_status         = o_stat_r;

endmodule
